[sv/ipdt_pkg.sv]
// Shared types, register indexes and reset values for the IR pulse-distance transmitter.
// No dependencies.
package ipdt_pkg;

  localparam int unsigned MAX_BYTES_DEF = 16;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 20;
  localparam int unsigned SPACE_W       = 20;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HDR    = 3'd1,
    PH_HSPACE = 3'd2,
    PH_BURST  = 3'd3,
    PH_BSPACE = 3'd4,
    PH_FINAL  = 3'd5
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARRIER_HIGH = 3'd0,
    REG_CARRIER_LOW  = 3'd1,
    REG_PULSES       = 3'd2,
    REG_HDR_BURSTS   = 3'd3,
    REG_HDR_SPACE    = 3'd4,
    REG_ZERO_SPACE   = 3'd5,
    REG_ONE_SPACE    = 3'd6
  } reg_e;

  typedef struct packed {
    logic [7:0]         carrier_high_ticks;
    logic [7:0]         carrier_low_ticks;
    logic [5:0]         pulses_per_burst;
    logic [3:0]         header_bursts;
    logic [SPACE_W-1:0] header_space_ticks;
    logic [SPACE_W-1:0] zero_space_ticks;
    logic [SPACE_W-1:0] one_space_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    carrier_high_ticks: 8'd9,
    carrier_low_ticks:  8'd17,
    pulses_per_burst:   6'd15,
    header_bursts:      4'd8,
    header_space_ticks: 20'd1612,
    zero_space_ticks:   20'd420,
    one_space_ticks:    20'd1214
  };

  typedef struct packed {
    op_e        op;
    logic [7:0] byte_value;
  } item_t;

endpackage

[sv/ipdt_front.sv]
// Front end: decodes incoming transactions and buffers them in a two-entry queue.
// Depends on ipdt_pkg.
module ipdt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    action_i,
  input  logic [7:0]    byte_value_i,
  output logic          q_valid_o,
  output ipdt_pkg::item_t q_item_o,
  input  logic          q_pop_i
);
  import ipdt_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  op_e        op;

  assign op = op_e'(action_i);

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{op: op, byte_value: byte_value_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("queue popped while empty");

endmodule

[sv/ipdt_back.sv]
// Back end: frame store, waveform sequencer and output register.
// Depends on ipdt_pkg.
module ipdt_back #(
  parameter int unsigned MAX_BYTES = ipdt_pkg::MAX_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ipdt_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  ipdt_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            led_level_o,
  output logic            busy_res_o,
  output logic            frame_done_o,
  output logic            load_dropped_o
);
  import ipdt_pkg::*;

  localparam int unsigned AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned CW = $clog2(MAX_BYTES + 1);

  logic [7:0]    store_mem [MAX_BYTES];
  logic [7:0]    rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  phase_e        phase_q, phase_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d, idx_inc;
  logic [2:0]    bit_q, bit_d;
  logic [7:0]    shift_q, shift_d;
  logic [3:0]    burst_q, burst_d;
  logic [5:0]    pulse_q, pulse_d;
  logic [SPACE_W-1:0] tick_q, tick_d;

  logic out_valid_q;
  logic led_q, busy_q, done_q, dropped_q;
  logic led, done, dropped;

  logic [7:0]  eff_h, eff_l;
  logic [5:0]  eff_p;
  logic [8:0]  period;
  logic [SPACE_W:0] tick_inc;
  logic [6:0]  pulse_inc;
  logic [4:0]  burst_inc;
  logic        cyc_end, burst_end, busy;
  logic [SPACE_W-1:0] tick_nxt, space;
  logic [5:0]  pulse_nxt;
  logic        bursts_done, header_done, bit_done;

  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  assign eff_h     = (cfg_i.carrier_high_ticks == 8'd0) ? 8'd1 : cfg_i.carrier_high_ticks;
  assign eff_l     = (cfg_i.carrier_low_ticks == 8'd0) ? 8'd1 : cfg_i.carrier_low_ticks;
  assign eff_p     = (cfg_i.pulses_per_burst == 6'd0) ? 6'd1 : cfg_i.pulses_per_burst;
  assign period    = {1'b0, eff_h} + {1'b0, eff_l};
  assign tick_inc  = {1'b0, tick_q} + {{SPACE_W{1'b0}}, 1'b1};
  assign cyc_end   = tick_inc >= {{(SPACE_W - 8){1'b0}}, period};
  assign pulse_inc = {1'b0, pulse_q} + 7'd1;
  assign burst_end = cyc_end && (pulse_inc >= {1'b0, eff_p});
  assign tick_nxt  = cyc_end ? '0 : tick_inc[SPACE_W-1:0];
  assign pulse_nxt = cyc_end ? (burst_end ? 6'd0 : pulse_inc[5:0]) : pulse_q;
  assign burst_inc = {1'b0, burst_q} + 5'd1;
  assign idx_inc   = idx_q + {{(CW - 1){1'b0}}, 1'b1};
  assign space     = shift_q[7] ? cfg_i.one_space_ticks : cfg_i.zero_space_ticks;
  assign busy      = (phase_q != PH_IDLE);

  assign rd_addr = (phase_q == PH_BURST || phase_q == PH_BSPACE) ? idx_inc[AW-1:0] : '0;
  assign wr_en   = q_pop_o && (q_item_i.op == OP_LOAD) && !busy &&
                   (count_q < CW'(MAX_BYTES));

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    idx_d       = idx_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    burst_d     = burst_q;
    pulse_d     = pulse_q;
    tick_d      = tick_q;
    done        = 1'b0;
    dropped     = 1'b0;
    bursts_done = 1'b0;
    header_done = 1'b0;
    bit_done    = 1'b0;
    led = (phase_q == PH_HDR || phase_q == PH_BURST || phase_q == PH_FINAL) &&
          ({{(SPACE_W - 8){1'b0}}, eff_h} > tick_q);

    case (q_item_i.op)
      OP_LOAD: begin
        if (wr_en) begin
          count_d = count_q + {{(CW - 1){1'b0}}, 1'b1};
        end else begin
          dropped = 1'b1;
        end
      end
      OP_START: begin
        if (!busy) begin
          burst_d = 4'd0;
          if (cfg_i.header_bursts != 4'd0) begin
            phase_d = PH_HDR;
            pulse_d = 6'd0;
            tick_d  = '0;
          end else begin
            bursts_done = 1'b1;
          end
        end
      end
      OP_TICK: begin
        unique case (phase_q)
          PH_IDLE: ;
          PH_HDR: begin
            pulse_d = pulse_nxt;
            tick_d  = tick_nxt;
            if (burst_end) begin
              burst_d = burst_inc[3:0];
              if (burst_inc >= {1'b0, cfg_i.header_bursts}) begin
                burst_d     = 4'd0;
                bursts_done = 1'b1;
              end
            end
          end
          PH_HSPACE: begin
            tick_d = tick_inc[SPACE_W-1:0];
            if (tick_inc >= {1'b0, cfg_i.header_space_ticks}) begin
              header_done = 1'b1;
            end
          end
          PH_BURST: begin
            pulse_d = pulse_nxt;
            tick_d  = tick_nxt;
            if (burst_end) begin
              if (space != '0) begin
                phase_d = PH_BSPACE;
                tick_d  = '0;
              end else begin
                bit_done = 1'b1;
              end
            end
          end
          PH_BSPACE: begin
            tick_d = tick_inc[SPACE_W-1:0];
            if (tick_inc >= {1'b0, space}) begin
              bit_done = 1'b1;
            end
          end
          PH_FINAL: begin
            pulse_d = pulse_nxt;
            tick_d  = tick_nxt;
            if (burst_end) begin
              done    = 1'b1;
              phase_d = PH_IDLE;
              count_d = '0;
              idx_d   = '0;
              bit_d   = 3'd0;
              shift_d = 8'd0;
              burst_d = 4'd0;
              pulse_d = 6'd0;
              tick_d  = '0;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      default: ;
    endcase

    if (bursts_done) begin
      if (cfg_i.header_space_ticks != '0) begin
        phase_d = PH_HSPACE;
        tick_d  = '0;
      end else begin
        header_done = 1'b1;
      end
    end

    if (header_done) begin
      pulse_d = 6'd0;
      tick_d  = '0;
      if (count_q != '0) begin
        idx_d   = '0;
        bit_d   = 3'd0;
        shift_d = rd_q;
        phase_d = PH_BURST;
      end else begin
        phase_d = PH_FINAL;
      end
    end

    if (bit_done) begin
      shift_d = {shift_q[6:0], 1'b0};
      pulse_d = 6'd0;
      tick_d  = '0;
      phase_d = PH_BURST;
      if (bit_q == 3'd7) begin
        bit_d = 3'd0;
        idx_d = idx_inc;
        if (idx_inc < count_q) begin
          shift_d = rd_q;
        end else begin
          phase_d = PH_FINAL;
        end
      end else begin
        bit_d = bit_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      bit_q       <= 3'd0;
      shift_q     <= 8'd0;
      burst_q     <= 4'd0;
      pulse_q     <= 6'd0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_q <= phase_d;
        count_q <= count_d;
        idx_q   <= idx_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        burst_q <= burst_d;
        pulse_q <= pulse_d;
        tick_q  <= tick_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      led_q     <= led;
      busy_q    <= (phase_d != PH_IDLE);
      done_q    <= done;
      dropped_q <= dropped;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[count_q[AW-1:0]] <= q_item_i.byte_value;
    end
    if (wr_en && (count_q[AW-1:0] == rd_addr)) begin
      rd_q <= q_item_i.byte_value;
    end else begin
      rd_q <= store_mem[rd_addr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign led_level_o    = led_q;
  assign busy_res_o     = busy_q;
  assign frame_done_o   = done_q;
  assign load_dropped_o = dropped_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(MAX_BYTES))
    else $error("byte count beyond store capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> !busy_q)
    else $error("frame end reported while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_item_i.op == OP_LOAD && busy) |=> (out_valid_q && dropped_q))
    else $error("load during transmission not flagged");

endmodule

[sv/ir_pulse_distance_transmitter.sv]
// IR pulse-distance transmitter top level: configuration registers, front end and back end.
// A result passes through the two-entry queue and the output register once accepted.
// Throughput: one transaction per cycle when not stalled; the back end steps once per item.
// A two-entry queue separates acceptance from the sequencer; the output register holds results.
// Reset (async, active low) clears control state and loads register defaults; store undefined.
module ir_pulse_distance_transmitter #(
  parameter int unsigned MAX_BYTES = ipdt_pkg::MAX_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ipdt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ipdt_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic [7:0]                         byte_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               led_level_o,
  output logic                               busy_res_o,
  output logic                               frame_done_o,
  output logic                               load_dropped_o
);
  import ipdt_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  q_valid, q_pop;
  item_t q_item;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CARRIER_HIGH: cfg_d.carrier_high_ticks = cfg_wdata_i[7:0];
        REG_CARRIER_LOW:  cfg_d.carrier_low_ticks  = cfg_wdata_i[7:0];
        REG_PULSES:       cfg_d.pulses_per_burst   = cfg_wdata_i[5:0];
        REG_HDR_BURSTS:   cfg_d.header_bursts      = cfg_wdata_i[3:0];
        REG_HDR_SPACE:    cfg_d.header_space_ticks = cfg_wdata_i[SPACE_W-1:0];
        REG_ZERO_SPACE:   cfg_d.zero_space_ticks   = cfg_wdata_i[SPACE_W-1:0];
        REG_ONE_SPACE:    cfg_d.one_space_ticks    = cfg_wdata_i[SPACE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ipdt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .byte_value_i (byte_value_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  ipdt_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .led_level_o    (led_level_o),
    .busy_res_o     (busy_res_o),
    .frame_done_o   (frame_done_o),
    .load_dropped_o (load_dropped_o)
  );

endmodule

[bench/tb_ir_pulse_distance_transmitter.sv]
// Self-checking bench for ir_pulse_distance_transmitter: directed rows, then random frames.
// Keeps its own model of the LED waveform and register shadow; depends on ipdt_pkg and the RTL.
module tb_ir_pulse_distance_transmitter;
  timeunit 1ns;
  timeprecision 1ps;
  import ipdt_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_BYTES_DEF;
  localparam int unsigned LIVE_TARGET = 750;
  localparam int unsigned QUIET_LIMIT = 1000;

  typedef struct packed {
    logic led_level;
    logic busy;
    logic frame_done;
    logic load_dropped;
  } tx_result_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] val;
    logic       typed;
    tx_result_t want;
  } script_row_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [1:0]            action       = OP_NONE;
  logic [7:0]            byte_value   = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic                  led_level;
  logic                  busy_res;
  logic                  frame_done;
  logic                  load_dropped;

  // waveform model state
  cfg_t        knobs = CFG_RESET;
  logic [7:0]  store_img [STORE_DEPTH] = '{default: 8'h00};
  phase_e      ph     = PH_IDLE;
  int unsigned nbytes = 0;
  int unsigned bidx   = 0;
  int unsigned bitn   = 0;
  logic [7:0]  shreg  = 8'h00;
  int unsigned burstn = 0;
  int unsigned pulsen = 0;
  int unsigned tcount = 0;

  tx_result_t  forecast_q [$];
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned live_items    = 0;
  int unsigned frames_done   = 0;
  int unsigned loads_refused = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left    = 0;
  int unsigned quiet_cycles  = 0;

  script_row_t opening_rows [25];

  ir_pulse_distance_transmitter u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .byte_value_i   (byte_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .led_level_o    (led_level),
    .busy_res_o     (busy_res),
    .frame_done_o   (frame_done),
    .load_dropped_o (load_dropped)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned at_least_one(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void begin_burst(phase_e p);
    ph     = p;
    pulsen = 0;
    tcount = 0;
  endfunction

  function automatic void leave_header();
    if (nbytes > 0) begin
      bidx  = 0;
      bitn  = 0;
      shreg = store_img[0];
      begin_burst(PH_BURST);
    end else begin
      begin_burst(PH_FINAL);
    end
  endfunction

  function automatic void leave_bursts();
    if (knobs.header_space_ticks > 0) begin
      ph     = PH_HSPACE;
      tcount = 0;
    end else begin
      leave_header();
    end
  endfunction

  function automatic void next_data_bit();
    shreg = shreg << 1;
    if (bitn >= 7) begin
      bitn = 0;
      bidx++;
      if (bidx < nbytes && bidx < STORE_DEPTH) begin
        shreg = store_img[bidx];
        begin_burst(PH_BURST);
      end else begin
        begin_burst(PH_FINAL);
      end
    end else begin
      bitn++;
      begin_burst(PH_BURST);
    end
  endfunction

  function automatic bit burst_step();
    tcount++;
    if (tcount >= at_least_one(knobs.carrier_high_ticks) +
                  at_least_one(knobs.carrier_low_ticks)) begin
      tcount = 0;
      pulsen++;
      if (pulsen >= at_least_one(knobs.pulses_per_burst)) begin
        pulsen = 0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int unsigned bit_space();
    return shreg[7] ? knobs.one_space_ticks : knobs.zero_space_ticks;
  endfunction

  function automatic tx_result_t advance_waveform(op_e op, logic [7:0] val);
    tx_result_t r;
    bit         was_busy;
    r.led_level    = (ph == PH_HDR || ph == PH_BURST || ph == PH_FINAL) &&
                     (tcount < at_least_one(knobs.carrier_high_ticks));
    r.frame_done   = 1'b0;
    r.load_dropped = 1'b0;
    was_busy       = (ph != PH_IDLE);
    case (op)
      OP_LOAD: begin
        if (was_busy || nbytes >= STORE_DEPTH) begin
          r.load_dropped = 1'b1;
        end else begin
          store_img[nbytes] = val;
          nbytes++;
        end
      end
      OP_START: begin
        if (!was_busy) begin
          burstn = 0;
          if (knobs.header_bursts > 0) begin_burst(PH_HDR);
          else leave_bursts();
        end
      end
      OP_TICK: begin
        if (was_busy) begin
          case (ph)
            PH_HDR: begin
              if (burst_step()) begin
                burstn++;
                if (burstn >= knobs.header_bursts) begin
                  burstn = 0;
                  leave_bursts();
                end
              end
            end
            PH_HSPACE: begin
              tcount++;
              if (tcount >= knobs.header_space_ticks) leave_header();
            end
            PH_BURST: begin
              if (burst_step()) begin
                if (bit_space() > 0) begin
                  ph     = PH_BSPACE;
                  tcount = 0;
                end else begin
                  next_data_bit();
                end
              end
            end
            PH_BSPACE: begin
              tcount++;
              if (tcount >= bit_space()) next_data_bit();
            end
            PH_FINAL: begin
              if (burst_step()) begin
                r.frame_done = 1'b1;
                ph     = PH_IDLE;
                nbytes = 0;
                bidx   = 0;
                bitn   = 0;
                shreg  = 8'h00;
                burstn = 0;
                pulsen = 0;
                tcount = 0;
              end
            end
            default: ph = PH_IDLE;
          endcase
        end
      end
      default: ;
    endcase
    r.busy = (ph != PH_IDLE);
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
  endtask

  task automatic send_item(op_e op, logic [7:0] val, bit typed = 1'b0, tx_result_t want = '0);
    int unsigned gap;
    tx_result_t  guess;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    action     <= op;
    byte_value <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    guess = advance_waveform(op, val);
    live_items++;
    frames_done   += guess.frame_done;
    loads_refused += guess.load_dropped;
    forecast_q.push_back(typed ? want : guess);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (forecast_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(cfg_t s);
    settle();
    put_reg(REG_CARRIER_HIGH, CFG_DATA_W'(s.carrier_high_ticks));
    put_reg(REG_CARRIER_LOW, CFG_DATA_W'(s.carrier_low_ticks));
    put_reg(REG_PULSES, CFG_DATA_W'(s.pulses_per_burst));
    put_reg(REG_HDR_BURSTS, CFG_DATA_W'(s.header_bursts));
    put_reg(REG_HDR_SPACE, s.header_space_ticks);
    put_reg(REG_ZERO_SPACE, s.zero_space_ticks);
    put_reg(REG_ONE_SPACE, s.one_space_ticks);
    cfg_we <= 1'b0;
    knobs = s;
    settings_used++;
  endtask

  task automatic shuffle_settings();
    cfg_t s;
    s.carrier_high_ticks = 8'($urandom_range(0, 3));
    s.carrier_low_ticks  = 8'($urandom_range(0, 3));
    s.pulses_per_burst   = 6'($urandom_range(0, 3));
    s.header_bursts      = 4'($urandom_range(0, 3));
    s.header_space_ticks = SPACE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(6, 40) :
                                                                  $urandom_range(0, 5));
    s.zero_space_ticks   = SPACE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(6, 40) :
                                                                  $urandom_range(0, 5));
    s.one_space_ticks    = SPACE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(6, 40) :
                                                                  $urandom_range(0, 5));
    apply_settings(s);
  endtask

  task automatic drain_frame(int unsigned noise_pct);
    int unsigned pick;
    while (ph != PH_IDLE) begin
      pick = $urandom_range(0, 99);
      if (pick >= noise_pct) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      else if (pick % 3 == 0) send_item(OP_LOAD, 8'($urandom_range(0, 255)));
      else if (pick % 3 == 1) send_item(OP_START, 8'($urandom_range(0, 255)));
      else send_item(OP_NONE, 8'($urandom_range(0, 255)));
    end
  endtask

  // receiver back-pressure: free, light, heavy and periodic spells
  initial begin
    int unsigned mode;
    int unsigned span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      for (int unsigned k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= (k % 4 == 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    tx_result_t got;
    tx_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {led_level, busy_res, frame_done, load_dropped};
      if (forecast_q.size() == 0) begin
        flag_mismatch("result with no transaction pending");
      end else begin
        want = forecast_q.pop_front();
        if (got.led_level !== want.led_level)
          flag_mismatch($sformatf("led_level %b, want %b", got.led_level, want.led_level));
        if (got.busy !== want.busy)
          flag_mismatch($sformatf("busy_res %b, want %b", got.busy, want.busy));
        if (got.frame_done !== want.frame_done)
          flag_mismatch($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
        if (got.load_dropped !== want.load_dropped)
          flag_mismatch($sformatf("load_dropped %b, want %b", got.load_dropped,
                                  want.load_dropped));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    opening_rows = '{
      '{OP_TICK,  8'h00, 1'b1, 4'b0000},
      '{OP_NONE,  8'h3C, 1'b1, 4'b0000},
      '{OP_LOAD,  8'h00, 1'b1, 4'b0000},
      '{OP_LOAD,  8'hFF, 1'b1, 4'b0000},
      '{OP_LOAD,  8'h80, 1'b1, 4'b0000},
      '{OP_LOAD,  8'h01, 1'b1, 4'b0000},
      '{OP_LOAD,  8'h55, 1'b1, 4'b0000},
      '{OP_LOAD,  8'hAA, 1'b1, 4'b0000},
      '{OP_LOAD,  8'h7F, 1'b1, 4'b0000},
      '{OP_LOAD,  8'hFE, 1'b1, 4'b0000},
      '{OP_LOAD,  8'h0F, 1'b1, 4'b0000},
      '{OP_LOAD,  8'hF0, 1'b1, 4'b0000},
      '{OP_LOAD,  8'h33, 1'b1, 4'b0000},
      '{OP_LOAD,  8'hCC, 1'b1, 4'b0000},
      '{OP_LOAD,  8'h12, 1'b1, 4'b0000},
      '{OP_LOAD,  8'h34, 1'b1, 4'b0000},
      '{OP_LOAD,  8'hC3, 1'b1, 4'b0000},
      '{OP_LOAD,  8'h96, 1'b1, 4'b0000},
      '{OP_LOAD,  8'h5A, 1'b1, 4'b0001},
      '{OP_START, 8'h00, 1'b1, 4'b0100},
      '{OP_START, 8'hFF, 1'b1, 4'b1100},
      '{OP_LOAD,  8'h77, 1'b1, 4'b1101},
      '{OP_NONE,  8'hFF, 1'b1, 4'b1100},
      '{OP_TICK,  8'hA5, 1'b1, 4'b1100},
      '{OP_TICK,  8'h5A, 1'b0, 4'b0000}
    };
  end

  initial begin
    int unsigned pick;
    int unsigned nload;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_rows[i])
      send_item(opening_rows[i].op, opening_rows[i].val, opening_rows[i].typed,
                opening_rows[i].want);

    // shrink timing mid-frame, with every register at zero
    apply_settings('0);
    drain_frame(0);
    send_item(OP_START, 8'h00);
    drain_frame(0);

    // top of every register range, part of one frame
    apply_settings('{8'd255, 8'd255, 6'd63, 4'd15, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF});
    send_item(OP_LOAD, 8'h81);
    send_item(OP_START, 8'h7E);
    repeat (40) send_item(OP_TICK, 8'($urandom_range(0, 255)));

    shuffle_settings();
    drain_frame(0);

    while (live_items < LIVE_TARGET) begin
      if ($urandom_range(0, 1) == 0) shuffle_settings();
      pick  = $urandom_range(0, 99);
      nload = (pick < 10) ? 0 : (pick < 80) ? $urandom_range(1, 3) :
              (pick < 95) ? $urandom_range(4, 7) : $urandom_range(15, 18);
      repeat ($urandom_range(0, 2))
        send_item($urandom_range(0, 1) ? OP_TICK : OP_NONE, 8'($urandom_range(0, 255)));
      repeat (nload) begin
        send_item(OP_LOAD, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 11) == 0) send_item(OP_NONE, 8'($urandom_range(0, 255)));
      end
      send_item(OP_START, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) send_item(OP_START, 8'($urandom_range(0, 255)));
      drain_frame(15);
    end

    in_valid <= 1'b0;
    while (forecast_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (forecast_q.size() != 0) flag_mismatch("results still outstanding at the end");

    $display("Run covered %0d results under %0d register settings.", results_seen,
             settings_used);
    $display("Frames completed: %0d, loads refused: %0d, mismatches: %0d.", frames_done,
             loads_refused, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
